FILE: sv/cttu_pkg.sv
// Shared types and constants of the command text tokenizer.
package cttu_pkg;

    // Width of the line counter and of every line field.
    localparam int LINE_BITS = 16;

    // Depth of the result queue and the width of its pointers and fill count.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    // Characters that steer the scanner.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_TERM   = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    // Report status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_MISSING_SEMI = 3'd1;
    localparam logic [2:0] ST_NL_IN_QUOTE = 3'd2;
    localparam logic [2:0] ST_OPEN_QUOTE  = 3'd3;
    localparam logic [2:0] ST_OPEN_COMMENT = 3'd4;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_CR     = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_BLOCK  = 3'd4,
        MODE_BSTAR  = 3'd5,
        MODE_QUOTE  = 3'd6
    } scan_mode_t;

    // One result item.
    typedef struct packed {
        logic [1:0]           out_kind;
        logic [7:0]           out_char;
        logic [LINE_BITS-1:0] line;
        logic [2:0]           status;
        logic                 fragment_dropped;
        logic                 last;
    } result_t;

    // Results of one input byte, handed from the scanner to the queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

FILE: sv/cttu_in_if.sv
// Input channel: one text byte or an end-of-text mark per transaction.
interface cttu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

FILE: sv/cttu_out_if.sv
// Output channel: one kept character, terminator or report per transaction.
interface cttu_out_if import cttu_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [1:0]           out_kind;
    logic [7:0]           out_char;
    logic [LINE_BITS-1:0] line;
    logic [2:0]           status;
    logic                 fragment_dropped;
    logic                 last;

    modport source (output valid, output out_kind, output out_char, output line,
                    output status, output fragment_dropped, output last, input ready);
    modport sink (input valid, input out_kind, input out_char, input line,
                  input status, input fragment_dropped, input last, output ready);
endinterface

FILE: sv/command_text_tokenizer_unit.sv
// Top level of the command text tokenizer.
// Takes one text byte per transaction and gives the kept command characters,
// a terminator per ';' outside quotes and comments with its line, and a status
// report at end of text (end_of_text high or a zero byte). A byte is accepted
// in every cycle as long as results are taken: it is held in the input register,
// where the scanner state is updated in a single pass, and its results (none,
// one, two, or one report) go into a four-entry result queue that hands out one
// result per cycle while the receiver is ready. Between acceptance and the first
// result lie the input register and the queue entry. A byte that yields two
// results (a held '/' or CR followed by a kept character) writes both at once.
module command_text_tokenizer_unit import cttu_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    cttu_in_if.sink    text_in,
    cttu_out_if.source token_out
);

    push_t   push;
    logic    room;
    result_t head;

    // Scanning stage.
    cttu_scanner u_scanner (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_in.valid),
        .in_ready (text_in.ready),
        .in_byte  (text_in.data_byte),
        .in_eot   (text_in.end_of_text),
        .room     (room),
        .push     (push)
    );

    // Result queue.
    cttu_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (token_out.valid),
        .out_ready (token_out.ready),
        .out_item  (head)
    );

    // Output payload.
    assign token_out.out_kind         = head.out_kind;
    assign token_out.out_char         = head.out_char;
    assign token_out.line             = head.line;
    assign token_out.status           = head.status;
    assign token_out.fragment_dropped = head.fragment_dropped;
    assign token_out.last             = head.last;

endmodule

FILE: sv/cttu_scanner.sv
// Input register, scanner state and the per-byte scanning logic.
module cttu_scanner import cttu_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_eot,
    input  logic       room,
    output push_t      push
);

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    logic                 hold_valid_reg;
    logic [7:0]           hold_byte_reg;
    logic                 hold_eot_reg;
    logic                 advance;

    scan_mode_t           mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] comment_line_reg, comment_line_next;
    logic                 open_reg, open_next;
    logic [2:0]           err_reg, err_next;
    logic [LINE_BITS-1:0] err_line_reg, err_line_next;

    logic                 run_normal;
    logic                 held_emit;
    logic [7:0]           held_char;
    logic                 open_eff;
    logic                 norm_emit;
    result_t              norm_res;
    result_t              held_res;
    result_t              report_res;
    logic                 is_report;
    logic [LINE_BITS-1:0] line_inc;

    // The held item moves on when the queue has room for two results.
    assign advance  = hold_valid_reg && room;
    assign in_ready = !hold_valid_reg || room;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_byte_reg <= in_byte;
            hold_eot_reg  <= in_eot;
        end
    end

    // Scanner state, updated once per byte that moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_NORMAL;
            line_reg         <= LINE_ONE;
            comment_line_reg <= LINE_ONE;
            open_reg         <= 1'b0;
            err_reg          <= ST_OK;
            err_line_reg     <= '0;
        end
        else if (advance)
        begin
            mode_reg         <= mode_next;
            line_reg         <= line_next;
            comment_line_reg <= comment_line_next;
            open_reg         <= open_next;
            err_reg          <= err_next;
            err_line_reg     <= err_line_next;
        end
    end

    // Saturating line increment.
    assign line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_ONE;

    // Next state and results for the held byte.
    always_comb
    begin
        mode_next         = mode_reg;
        line_next         = line_reg;
        comment_line_next = comment_line_reg;
        open_next         = open_reg;
        err_next          = err_reg;
        err_line_next     = err_line_reg;
        run_normal        = 1'b0;
        held_emit         = 1'b0;
        held_char         = CH_SLASH;
        norm_emit         = 1'b0;
        is_report         = 1'b0;
        open_eff          = open_reg;

        norm_res                  = '0;
        norm_res.out_char         = hold_byte_reg;
        norm_res.out_kind         = KIND_CHAR;
        norm_res.line             = line_reg;

        report_res                = '0;
        report_res.out_kind       = KIND_REPORT;
        report_res.line           = line_reg;
        report_res.status         = ST_OK;
        report_res.last           = 1'b1;

        if (hold_eot_reg || hold_byte_reg == CH_NUL)
        begin
            // End of text: report and return to the reset state.
            is_report = 1'b1;
            if (err_reg != ST_OK)
            begin
                report_res.status = err_reg;
                report_res.line   = err_line_reg;
            end
            else if (mode_reg == MODE_QUOTE)
            begin
                report_res.status = ST_OPEN_QUOTE;
            end
            else if (mode_reg == MODE_BLOCK || mode_reg == MODE_BSTAR)
            begin
                report_res.status = ST_OPEN_COMMENT;
                report_res.line   = comment_line_reg;
            end
            else
            begin
                report_res.fragment_dropped = open_reg || mode_reg == MODE_SLASH
                                              || mode_reg == MODE_CR;
            end
            mode_next         = MODE_NORMAL;
            line_next         = LINE_ONE;
            comment_line_next = LINE_ONE;
            open_next         = 1'b0;
            err_next          = ST_OK;
            err_line_next     = '0;
        end
        else if (err_reg == ST_OK)
        begin
            unique case (mode_reg)
                MODE_SLASH:
                begin
                    if (hold_byte_reg == CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (hold_byte_reg == CH_STAR)
                    begin
                        mode_next         = MODE_BLOCK;
                        comment_line_next = line_reg;
                    end
                    else
                    begin
                        held_emit  = 1'b1;
                        held_char  = CH_SLASH;
                        run_normal = 1'b1;
                    end
                end
                MODE_CR:
                begin
                    mode_next = MODE_NORMAL;
                    if (hold_byte_reg == CH_LF)
                    begin
                        if (open_reg)
                        begin
                            err_next      = ST_MISSING_SEMI;
                            err_line_next = line_reg;
                        end
                        else
                        begin
                            line_next = line_inc;
                        end
                    end
                    else
                    begin
                        held_emit  = 1'b1;
                        held_char  = CH_CR;
                        run_normal = 1'b1;
                    end
                end
                MODE_LINE:
                begin
                    if (hold_byte_reg == CH_LF)
                    begin
                        line_next = line_inc;
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_BLOCK, MODE_BSTAR:
                begin
                    if (hold_byte_reg == CH_SLASH && mode_reg == MODE_BSTAR)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else if (hold_byte_reg == CH_STAR)
                    begin
                        mode_next = MODE_BSTAR;
                    end
                    else
                    begin
                        if (hold_byte_reg == CH_LF)
                        begin
                            line_next = line_inc;
                        end
                        mode_next = MODE_BLOCK;
                    end
                end
                MODE_QUOTE:
                begin
                    if (hold_byte_reg == CH_LF)
                    begin
                        err_next      = ST_NL_IN_QUOTE;
                        err_line_next = line_reg;
                    end
                    else
                    begin
                        norm_emit = 1'b1;
                        if (hold_byte_reg == CH_QUOTE)
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                end
                default:
                begin
                    run_normal = 1'b1;
                end
            endcase

            // Ordinary handling of a byte outside comments and quotes.
            if (run_normal)
            begin
                open_eff  = held_emit ? 1'b1 : open_reg;
                open_next = open_eff;
                mode_next = MODE_NORMAL;
                priority if (hold_byte_reg == CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else if (hold_byte_reg == CH_QUOTE)
                begin
                    norm_emit = 1'b1;
                    open_next = 1'b1;
                    mode_next = MODE_QUOTE;
                end
                else if (hold_byte_reg == CH_SPACE)
                begin
                    open_next = open_eff;
                end
                else if (hold_byte_reg == CH_SEMI)
                begin
                    norm_emit         = 1'b1;
                    norm_res.out_kind = KIND_TERM;
                    open_next         = 1'b0;
                end
                else if (hold_byte_reg == CH_CR)
                begin
                    mode_next = MODE_CR;
                end
                else if (hold_byte_reg == CH_LF)
                begin
                    if (open_eff)
                    begin
                        err_next      = ST_MISSING_SEMI;
                        err_line_next = line_reg;
                    end
                    else
                    begin
                        line_next = line_inc;
                    end
                end
                else
                begin
                    norm_emit = 1'b1;
                    open_next = 1'b1;
                end
            end
        end
    end

    // Result for a held slash or carriage return that turned out to be text.
    always_comb
    begin
        held_res          = '0;
        held_res.out_kind = KIND_CHAR;
        held_res.out_char = held_char;
        held_res.line     = line_reg;
        held_res.last     = !norm_emit;
    end

    // Order the results of this byte for the queue.
    always_comb
    begin
        push        = '0;
        push.first  = held_emit ? held_res : norm_res;
        push.second = norm_res;
        push.first.last  = held_emit ? !norm_emit : 1'b1;
        push.second.last = 1'b1;
        if (advance)
        begin
            if (is_report)
            begin
                push.count = 2'd1;
                push.first = report_res;
            end
            else
            begin
                push.count = 2'(held_emit) + 2'(norm_emit);
            end
        end
    end

endmodule

FILE: sv/cttu_result_queue.sv
// Small result queue that takes up to two results at once and gives one per cycle while out_ready is high.
module cttu_result_queue import cttu_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    result_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                pop;
    logic [PTR_BITS-1:0] wr_ptr_plus1;

    // Room for two more results, not counting a pop in the same cycle.
    assign room      = count_reg <= CNT_BITS'(QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_BITS'(1);

    // Pointer and fill count arithmetic.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the results of one byte at consecutive slots.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

FILE: dv/cttu_token_checker.sv
// Scoreboard of the command text tokenizer: predicts each token and compares it with the output.
module cttu_token_checker import cttu_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    cttu_in_if   in_ch,
    cttu_out_if  out_ch,
    output int   mismatch_count,
    output int   pending_count
);

    // Predicted scanner state.
    scan_mode_t           mode;
    logic [LINE_BITS-1:0] line_no;
    logic [LINE_BITS-1:0] comment_line;
    logic                 cmd_open;
    logic [2:0]           err_code;
    logic [LINE_BITS-1:0] err_line;

    // Tokens of the byte being scanned, and tokens still owed by the block.
    result_t step_tokens[$];
    result_t expected_tokens[$];
    int      tokens_seen;

    // Return the scanner to its state after reset or after a report.
    task automatic clear_state();
        mode         = MODE_NORMAL;
        line_no      = LINE_BITS'(1);
        comment_line = LINE_BITS'(1);
        cmd_open     = 1'b0;
        err_code     = ST_OK;
        err_line     = '0;
    endtask

    task automatic add_token(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [LINE_BITS-1:0] ln, input logic [2:0] st,
                             input logic frag);
        result_t r;
        r = '0;
        r.out_kind         = kind;
        r.out_char         = ch;
        r.line             = ln;
        r.status           = st;
        r.fragment_dropped = frag;
        step_tokens.insert(step_tokens.size(), r);
    endtask

    // The line counter sticks at its maximum.
    task automatic bump_line();
        if (line_no != {LINE_BITS{1'b1}})
            line_no = line_no + 1'b1;
    endtask

    // A newline outside comments and quotes is an error while a command is open.
    task automatic end_of_line();
        if (cmd_open)
        begin
            err_code = ST_MISSING_SEMI;
            err_line = line_no;
        end
        else
            bump_line();
    endtask

    // A byte seen in normal mode.
    task automatic plain_byte(input logic [7:0] b);
        mode = MODE_NORMAL;
        if (b == CH_SLASH)
            mode = MODE_SLASH;
        else if (b == CH_QUOTE)
        begin
            add_token(KIND_CHAR, b, line_no, ST_OK, 1'b0);
            cmd_open = 1'b1;
            mode     = MODE_QUOTE;
        end
        else if (b == CH_SPACE)
        begin
            // Spaces outside quotes are dropped.
        end
        else if (b == CH_SEMI)
        begin
            add_token(KIND_TERM, b, line_no, ST_OK, 1'b0);
            cmd_open = 1'b0;
        end
        else if (b == CH_CR)
            mode = MODE_CR;
        else if (b == CH_LF)
            end_of_line();
        else
        begin
            add_token(KIND_CHAR, b, line_no, ST_OK, 1'b0);
            cmd_open = 1'b1;
        end
    endtask

    // Work out the tokens of one accepted byte and queue them.
    task automatic scan_byte(input logic [7:0] b, input logic eot);
        logic [2:0]           st;
        logic [LINE_BITS-1:0] ln;
        logic                 frag;
        result_t              r;
        int                   i;
        step_tokens.delete();
        if (eot || b == CH_NUL)
        begin
            // End of text: report the first error or the open construct, then restart.
            frag = 1'b0;
            if (err_code != ST_OK)
            begin
                st = err_code;
                ln = err_line;
            end
            else if (mode == MODE_QUOTE)
            begin
                st = ST_OPEN_QUOTE;
                ln = line_no;
            end
            else if (mode == MODE_BLOCK || mode == MODE_BSTAR)
            begin
                st = ST_OPEN_COMMENT;
                ln = comment_line;
            end
            else
            begin
                st   = ST_OK;
                ln   = line_no;
                frag = cmd_open || mode == MODE_SLASH || mode == MODE_CR;
            end
            add_token(KIND_REPORT, CH_NUL, ln, st, frag);
            clear_state();
        end
        else if (err_code == ST_OK)
        begin
            case (mode)
                MODE_SLASH:
                    if (b == CH_SLASH)
                        mode = MODE_LINE;
                    else if (b == CH_STAR)
                    begin
                        mode         = MODE_BLOCK;
                        comment_line = line_no;
                    end
                    else
                    begin
                        add_token(KIND_CHAR, CH_SLASH, line_no, ST_OK, 1'b0);
                        cmd_open = 1'b1;
                        plain_byte(b);
                    end
                MODE_CR:
                begin
                    mode = MODE_NORMAL;
                    if (b == CH_LF)
                        end_of_line();
                    else
                    begin
                        add_token(KIND_CHAR, CH_CR, line_no, ST_OK, 1'b0);
                        cmd_open = 1'b1;
                        plain_byte(b);
                    end
                end
                MODE_LINE:
                    if (b == CH_LF)
                    begin
                        bump_line();
                        mode = MODE_NORMAL;
                    end
                MODE_BLOCK, MODE_BSTAR:
                    if (b == CH_SLASH && mode == MODE_BSTAR)
                        mode = MODE_NORMAL;
                    else if (b == CH_STAR)
                        mode = MODE_BSTAR;
                    else
                    begin
                        if (b == CH_LF)
                            bump_line();
                        mode = MODE_BLOCK;
                    end
                MODE_QUOTE:
                    if (b == CH_LF)
                    begin
                        err_code = ST_NL_IN_QUOTE;
                        err_line = line_no;
                    end
                    else
                    begin
                        add_token(KIND_CHAR, b, line_no, ST_OK, 1'b0);
                        if (b == CH_QUOTE)
                            mode = MODE_NORMAL;
                    end
                default:
                    plain_byte(b);
            endcase
        end
        // The final token of the byte carries the last flag.
        for (i = 0; i < step_tokens.size(); i++)
        begin
            r      = step_tokens[i];
            r.last = (i == step_tokens.size() - 1);
            expected_tokens.insert(expected_tokens.size(), r);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [LINE_BITS-1:0] got,
                                   input logic [LINE_BITS-1:0] want);
        if (mismatch_count < 100)
            $display("token %0d: %s is %0h, expected %0h", tokens_seen, field, got, want);
        mismatch_count++;
    endtask

    // Compare one output transaction with the oldest predicted token.
    task automatic check_token();
        result_t seen;
        result_t want;
        seen.out_kind         = out_ch.out_kind;
        seen.out_char         = out_ch.out_char;
        seen.line             = out_ch.line;
        seen.status           = out_ch.status;
        seen.fragment_dropped = out_ch.fragment_dropped;
        seen.last             = out_ch.last;
        if (expected_tokens.size() == 0)
            report_mismatch("unexpected token, kind", LINE_BITS'(seen.out_kind), '0);
        else
        begin
            want = expected_tokens.pop_front();
            if (seen.out_kind !== want.out_kind)
                report_mismatch("out_kind", LINE_BITS'(seen.out_kind),
                                LINE_BITS'(want.out_kind));
            if (seen.out_char !== want.out_char)
                report_mismatch("out_char", LINE_BITS'(seen.out_char),
                                LINE_BITS'(want.out_char));
            if (seen.line !== want.line)
                report_mismatch("line", seen.line, want.line);
            if (seen.status !== want.status)
                report_mismatch("status", LINE_BITS'(seen.status), LINE_BITS'(want.status));
            if (seen.fragment_dropped !== want.fragment_dropped)
                report_mismatch("fragment_dropped", LINE_BITS'(seen.fragment_dropped),
                                LINE_BITS'(want.fragment_dropped));
            if (seen.last !== want.last)
                report_mismatch("last", LINE_BITS'(seen.last), LINE_BITS'(want.last));
        end
        tokens_seen++;
    endtask

    // Watch both channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            expected_tokens.delete();
            mismatch_count = 0;
            tokens_seen    = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_token();
            if (in_ch.valid && in_ch.ready)
                scan_byte(in_ch.data_byte, in_ch.end_of_text);
        end
        pending_count = expected_tokens.size();
    end

endmodule

FILE: dv/tb_command_text_tokenizer_unit.sv
// Testbench top of the command text tokenizer: clock, reset, byte stimulus and verdict.
module tb_command_text_tokenizer_unit;
    import cttu_pkg::*;

    localparam int CLOCK_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 700;

    logic clk = 1'b0;
    logic rst_n;

    cttu_in_if  text_ch();
    cttu_out_if token_ch();

    int   mismatch_total;
    int   results_waiting;
    int   items_sent;
    int   cycle_count = 0;
    bit   in_taken = 1'b0;
    bit   burst_mode = 1'b0;
    bit   hold_request = 1'b0;
    logic [7:0] text_q[$];

    command_text_tokenizer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_ch),
        .token_out (token_ch)
    );

    cttu_token_checker token_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (text_ch),
        .out_ch         (token_ch),
        .mismatch_count (mismatch_total),
        .pending_count  (results_waiting)
    );

    always #2 clk = ~clk;

    // Flag input transactions so that the sender can look at them at the falling edge.
    always @(posedge clk)
        in_taken <= text_ch.valid && text_ch.ready;

    // Guard against a hang.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CLOCK_LIMIT)
        begin
            $display("command_text_tokenizer_unit regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, a clean stretch in burst mode, one long hold-off on request.
    initial
    begin
        token_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                token_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
                token_ch.ready <= burst_mode || ($urandom_range(99) >= 8);
        end
    end

    // Offer one byte, with an occasional gap first, and wait until it is taken.
    task automatic send_byte(input logic [7:0] value, input logic eot);
        while (!burst_mode && $urandom_range(99) < 8)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.data_byte   <= value;
        text_ch.end_of_text <= eot;
        do
            @(negedge clk);
        while (!in_taken);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // Add one byte at the end of the text being built.
    task automatic append_char(input logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endtask

    // Any byte of a command word: no space, quote, slash, semicolon or line break.
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_QUOTE ||
               c == CH_SLASH || c == CH_SEMI);
        return c;
    endfunction

    // Nonzero byte with a strong bias toward the characters that steer the scanner.
    function automatic logic [7:0] noise_byte();
        logic [7:0] steer[7];
        steer = '{CH_LF, CH_CR, CH_SPACE, CH_QUOTE, CH_STAR, CH_SLASH, CH_SEMI};
        if ($urandom_range(1) == 0)
            return steer[3'($urandom_range(6))];
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic add_word();
        repeat ($urandom_range(1, 6)) append_char(word_char());
    endtask

    // One command: a mix of words, quoted text, comments, spaces and held bytes.
    task automatic add_command();
        logic [7:0] c;
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                    add_word();
                4:
                begin
                    append_char(CH_QUOTE);
                    repeat ($urandom_range(0, 5))
                    begin
                        do
                            c = 8'($urandom_range(1, 255));
                        while (c == CH_LF || c == CH_QUOTE);
                        append_char(c);
                    end
                    if ($urandom_range(29) == 0)
                        append_char(CH_LF);
                    append_char(CH_QUOTE);
                end
                5:
                begin
                    append_char(CH_SLASH);
                    append_char(CH_STAR);
                    repeat ($urandom_range(0, 5))
                        append_char(($urandom_range(3) == 0) ? CH_LF : word_char());
                    repeat ($urandom_range(1, 2)) append_char(CH_STAR);
                    append_char(CH_SLASH);
                end
                6:
                    append_char(CH_SPACE);
                7:
                begin
                    // A slash that does not open a comment.
                    do
                        c = word_char();
                    while (c == CH_STAR);
                    append_char(CH_SLASH);
                    append_char(c);
                end
                8:
                begin
                    append_char(CH_CR);
                    append_char(word_char());
                end
                default:
                begin
                    append_char(CH_SPACE);
                    append_char(CH_SPACE);
                end
            endcase
        end
        if ($urandom_range(39) != 0)
            append_char(CH_SEMI);
    endtask

    // One line: commands, an optional trailing line comment, then LF or CR LF.
    task automatic add_line();
        logic [7:0] c;
        repeat ($urandom_range(0, 3)) add_command();
        if ($urandom_range(3) == 0)
            append_char(CH_SPACE);
        if ($urandom_range(4) == 0)
        begin
            append_char(CH_SLASH);
            append_char(CH_SLASH);
            repeat ($urandom_range(0, 5))
            begin
                do
                    c = noise_byte();
                while (c == CH_LF);
                append_char(c);
            end
        end
        if ($urandom_range(2) == 0)
            append_char(CH_CR);
        append_char(CH_LF);
    endtask

    // Build one text: mostly well-formed lines, sometimes an open tail, sometimes noise.
    task automatic build_text();
        int tail;
        text_q.delete();
        if ($urandom_range(99) < 12)
            repeat ($urandom_range(4, 20)) append_char(noise_byte());
        else
        begin
            repeat ($urandom_range(1, 5)) add_line();
            tail = $urandom_range(99);
            if (tail < 8)
                add_word();
            else if (tail < 12)
            begin
                append_char(CH_QUOTE);
                add_word();
            end
            else if (tail < 16)
            begin
                append_char(CH_SLASH);
                append_char(CH_STAR);
            end
            else if (tail < 20)
                append_char(CH_SLASH);
            else if (tail < 24)
                append_char(CH_CR);
        end
    endtask

    // Main stimulus.
    initial
    begin
        int  base;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        items_sent = 0;
        text_ch.valid       = 1'b0;
        text_ch.data_byte   = 8'h00;
        text_ch.end_of_text = 1'b0;
        rst_n               = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Held slash before a character, dropped space, quoted ';' and CR, CR LF.
        send_text("a/b \";\015\";\015\n");
        // Line comment, then a block comment whose opening star does not close it.
        send_text("//x\n/*/\n*/");
        // Held CR before a character, then a newline inside an open command.
        send_text("\015");
        send_byte(8'hFF, 1'b0);
        send_text("\n");
        send_byte(CH_NUL, 1'b0);
        // Newline inside quotes, reported on end_of_text with a nonzero byte.
        send_text("\"\n");
        send_byte(8'h5A, 1'b1);
        // Unclosed quote.
        send_text("\"q");
        send_byte(CH_NUL, 1'b1);
        // Unclosed block comment on the second line.
        send_text("\n/*");
        send_byte(8'hA5, 1'b1);
        // End with a held slash, a held CR, and after a complete command.
        send_text("/");
        send_byte(CH_NUL, 1'b0);
        send_text("\015");
        send_byte(CH_NUL, 1'b1);
        send_text("k;");
        send_byte(CH_NUL, 1'b0);

        // Random texts.
        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            if (!hold_done && items_sent >= base + 150)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && items_sent >= base + 300)
            begin
                text_ch.valid <= 1'b0;
                do
                    @(negedge clk);
                while (results_waiting != 0);
                pause_done = 1'b1;
            end
            burst_mode = (items_sent >= base + 400) && (items_sent < base + 550);
            build_text();
            foreach (text_q[i])
                send_byte(text_q[i], 1'b0);
            if ($urandom_range(1) == 0)
                send_byte(8'($urandom_range(255)), 1'b1);
            else
                send_byte(CH_NUL, 1'b0);
        end
        burst_mode = 1'b0;

        // Drain and give the verdict.
        text_ch.valid <= 1'b0;
        while (results_waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_total == 0)
            $display("command_text_tokenizer_unit regression: pass");
        else
            $display("command_text_tokenizer_unit regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
sv/cttu_pkg.sv
sv/cttu_in_if.sv
sv/cttu_out_if.sv
sv/cttu_scanner.sv
sv/cttu_result_queue.sv
sv/command_text_tokenizer_unit.sv
dv/cttu_token_checker.sv
dv/tb_command_text_tokenizer_unit.sv
